>>> rtl/core/dam_pkg.sv
package dam_pkg;

   localparam int LINE_ADDR_BITS = 36;

   localparam int POLICY_W  = 3;
   localparam int CHAN_W    = 5;
   localparam int BANK_W    = 7;
   localparam int LPR_W     = 11;
   localparam int GANG_W    = 11;
   localparam int MEM_W     = 37;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 37;

   localparam int CH_OUT_W   = 4;
   localparam int BANK_OUT_W = 6;
   localparam int ROW_OUT_W  = 36;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_POLICY   = 3'd0,
      CSR_CHANNELS     = 3'd1,
      CSR_BANKS        = 3'd2,
      CSR_LINES_PER_ROW = 3'd3,
      CSR_GANG_SIZE    = 3'd4,
      CSR_MEMORY_LINES = 3'd5
   } csr_index_type;

   typedef enum logic [POLICY_W-1:0] {
      POL_ROW_STRIPE  = 3'd0,
      POL_PAIR_STRIPE = 3'd1,
      POL_GANG_STRIPE = 3'd2,
      POL_SKIP_STRIPE = 3'd3,
      POL_LINE_STRIPE = 3'd4
   } policy_type;

   localparam logic [POLICY_W-1:0] RST_POLICY   = 3'd0;
   localparam logic [CHAN_W-1:0]   RST_CHANNELS = 5'd2;
   localparam logic [BANK_W-1:0]   RST_BANKS    = 7'd16;
   localparam logic [LPR_W-1:0]    RST_LPR      = 11'd128;
   localparam logic [GANG_W-1:0]   RST_GANG     = 11'd4;
   localparam logic [MEM_W-1:0]    RST_MEM      = 37'd268435456;

endpackage

>>> rtl/core/dram_address_mapper_unit.sv
// Throughput: one beat per cycle while the response is not stalled.
// Pipeline: a gang-ratio divider, then five chained bit-per-stage dividers.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module dram_address_mapper_unit #(
   parameter int LINE_ADDR_BITS = dam_pkg::LINE_ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [LINE_ADDR_BITS-1:0]          req_line_address,
   input  logic                               req_is_writeback,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dam_pkg::CH_OUT_W-1:0]       rsp_channel_index,
   output logic [dam_pkg::BANK_OUT_W-1:0]     rsp_bank_index,
   output logic [dam_pkg::ROW_OUT_W-1:0]      rsp_row_index,
   output logic                               rsp_request_kind,
   output logic                               rsp_address_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dam_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = LINE_ADDR_BITS;
   localparam int LW = dam_pkg::LPR_W;
   localparam int CMPW = (AW > dam_pkg::MEM_W) ? AW : dam_pkg::MEM_W;

   logic [dam_pkg::POLICY_W-1:0] policy_ff;
   logic [dam_pkg::CHAN_W-1:0]   chan_ff;
   logic [dam_pkg::BANK_W-1:0]   banks_ff;
   logic [LW-1:0]                lpr_ff;
   logic [dam_pkg::GANG_W-1:0]   gang_ff;
   logic [dam_pkg::MEM_W-1:0]    mem_ff;

   logic advance;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= dam_pkg::RST_POLICY;
         chan_ff   <= dam_pkg::RST_CHANNELS;
         banks_ff  <= dam_pkg::RST_BANKS;
         lpr_ff    <= dam_pkg::RST_LPR;
         gang_ff   <= dam_pkg::RST_GANG;
         mem_ff    <= dam_pkg::RST_MEM;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dam_pkg::CSR_MAP_POLICY:    policy_ff <= csr_data[dam_pkg::POLICY_W-1:0];
            dam_pkg::CSR_CHANNELS:      chan_ff   <= csr_data[dam_pkg::CHAN_W-1:0];
            dam_pkg::CSR_BANKS:         banks_ff  <= csr_data[dam_pkg::BANK_W-1:0];
            dam_pkg::CSR_LINES_PER_ROW: lpr_ff    <= csr_data[LW-1:0];
            dam_pkg::CSR_GANG_SIZE:     gang_ff   <= csr_data[dam_pkg::GANG_W-1:0];
            dam_pkg::CSR_MEMORY_LINES:  mem_ff    <= csr_data[dam_pkg::MEM_W-1:0];
            default: ;
         endcase
      end
   end

   // gang ratio L/G
   logic          g_valid;
   logic [LW-1:0] g_quo;
   logic [LW-1:0] g_rem;
   logic [AW:0]   g_side;

   dam_div #(.DW(LW), .VW(LW), .SW(AW + 1)) u_div_gang (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid && req_ready), .in_num(lpr_ff), .in_den(gang_ff),
      .in_side({req_line_address, req_is_writeback}),
      .out_valid(g_valid), .out_quo(g_quo), .out_rem(g_rem), .out_side(g_side)
   );

   logic [AW-1:0] g_addr;
   logic          g_err;
   logic [LW-1:0] d1;
   logic [LW-2:0] d3;
   logic [LW-1:0] de;

   assign g_addr = g_side[AW:1];

   always_comb begin
      g_err = (CMPW'(g_addr) >= CMPW'(mem_ff)) || (chan_ff == '0) || (banks_ff == '0);
      d1 = LW'(1);
      d3 = (LW-1)'(1);
      de = LW'(1);
      case (policy_ff)
         dam_pkg::POL_ROW_STRIPE: begin
            g_err = g_err || (lpr_ff == '0);
            d1 = lpr_ff;
         end
         dam_pkg::POL_PAIR_STRIPE: begin
            g_err = g_err || (lpr_ff[LW-1:1] == '0);
            d1 = LW'(2);
            d3 = lpr_ff[LW-1:1];
         end
         dam_pkg::POL_GANG_STRIPE: begin
            g_err = g_err || (gang_ff == '0) || (g_quo == '0);
            d1 = gang_ff;
            de = g_quo;
         end
         dam_pkg::POL_SKIP_STRIPE: begin
            g_err = g_err || (lpr_ff[LW-1:1] == '0);
            d3 = (LW-1)'(2);
            de = {1'b0, lpr_ff[LW-1:1]};
         end
         dam_pkg::POL_LINE_STRIPE: begin
            g_err = g_err || (lpr_ff == '0);
            de = lpr_ff;
         end
         default: g_err = 1'b1;
      endcase
   end

   // a / d1
   logic          a_valid;
   logic [AW-1:0] a_quo;
   logic [LW-1:0] a_rem;
   logic [LW+1:0] a_side;

   dam_div #(.DW(AW), .VW(LW), .SW(LW + 2)) u_div_a (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(g_valid), .in_num(g_addr), .in_den(d1),
      .in_side({de, g_err, g_side[0]}),
      .out_valid(a_valid), .out_quo(a_quo), .out_rem(a_rem), .out_side(a_side)
   );

   // channel split
   logic                       b_valid;
   logic [AW-1:0]              b_quo;
   logic [dam_pkg::CHAN_W-1:0] b_rem;
   logic [LW+1:0]              b_side;

   dam_div #(.DW(AW), .VW(dam_pkg::CHAN_W), .SW(LW + 2)) u_div_chan (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(a_valid), .in_num(a_quo), .in_den(chan_ff), .in_side(a_side),
      .out_valid(b_valid), .out_quo(b_quo), .out_rem(b_rem), .out_side(b_side)
   );

   // row-group scaling
   localparam int CSW = LW + 2 + dam_pkg::CH_OUT_W;
   logic          c_valid;
   logic [AW-1:0] c_quo;
   logic [LW-2:0] c_rem;
   logic [CSW-1:0] c_side;

   dam_div #(.DW(AW), .VW(LW - 1), .SW(CSW)) u_div_mid (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(b_valid), .in_num(b_quo), .in_den(d3),
      .in_side({b_rem[dam_pkg::CH_OUT_W-1:0], b_side}),
      .out_valid(c_valid), .out_quo(c_quo), .out_rem(c_rem), .out_side(c_side)
   );

   // bank split
   logic                       d_valid;
   logic [AW-1:0]              d_quo;
   logic [dam_pkg::BANK_W-1:0] d_rem;
   logic [CSW-1:0]             d_side;

   dam_div #(.DW(AW), .VW(dam_pkg::BANK_W), .SW(CSW)) u_div_bank (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(c_valid), .in_num(c_quo), .in_den(banks_ff), .in_side(c_side),
      .out_valid(d_valid), .out_quo(d_quo), .out_rem(d_rem), .out_side(d_side)
   );

   // row scaling
   localparam int ESW = dam_pkg::BANK_OUT_W + dam_pkg::CH_OUT_W + 2;
   logic           e_valid;
   logic [AW-1:0]  e_quo;
   logic [LW-1:0]  e_rem;
   logic [ESW-1:0] e_side;

   dam_div #(.DW(AW), .VW(LW), .SW(ESW)) u_div_row (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(d_valid), .in_num(d_quo), .in_den(d_side[LW+1:2]),
      .in_side({d_rem[dam_pkg::BANK_OUT_W-1:0], d_side[CSW-1:LW+2], d_side[1:0]}),
      .out_valid(e_valid), .out_quo(e_quo), .out_rem(e_rem), .out_side(e_side)
   );

   logic e_err;
   assign e_err = e_side[1];

   assign rsp_valid         = e_valid;
   assign rsp_request_kind  = e_side[0];
   assign rsp_address_error = e_err;
   assign rsp_channel_index = e_err ? '0 : e_side[dam_pkg::CH_OUT_W+1:2];
   assign rsp_bank_index    = e_err ? '0 : e_side[ESW-1:dam_pkg::CH_OUT_W+2];
   assign rsp_row_index     = e_err ? '0 : dam_pkg::ROW_OUT_W'(e_quo);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_error |->
         rsp_channel_index == '0 && rsp_bank_index == '0 && rsp_row_index == '0)
      else $error("error beat carries nonzero mapping");

   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response stall");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_address_error))
      else $error("stalled response beat changed");

endmodule

>>> rtl/core/dam_div.sv
module dam_div #(
   parameter int DW = 36,
   parameter int VW = 11,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic [DW-1:0] in_num,
   input  logic [VW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] out_quo,
   output logic [VW-1:0] out_rem,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] valid_ff, valid_in;
   logic [DW-1:0] num_ff  [DW];
   logic [DW-1:0] num_in  [DW];
   logic [VW-1:0] rem_ff  [DW];
   logic [VW-1:0] rem_in  [DW];
   logic [VW-1:0] den_ff  [DW];
   logic [VW-1:0] den_in  [DW];
   logic [SW-1:0] side_ff [DW];
   logic [SW-1:0] side_in [DW];

   always_comb begin
      logic          pv;
      logic [DW-1:0] pn;
      logic [VW-1:0] pr;
      logic [VW-1:0] pd;
      logic [SW-1:0] ps;
      logic [VW:0]   trial;
      for (int k = 0; k < DW; k++) begin
         if (k == 0) begin
            pv = in_valid;
            pn = in_num;
            pr = '0;
            pd = in_den;
            ps = in_side;
         end else begin
            pv = valid_ff[k-1];
            pn = num_ff[k-1];
            pr = rem_ff[k-1];
            pd = den_ff[k-1];
            ps = side_ff[k-1];
         end
         trial = {pr, pn[DW-1]};
         if (trial >= {1'b0, pd}) begin
            rem_in[k] = VW'(trial - {1'b0, pd});
            num_in[k] = {pn[DW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[VW-1:0];
            num_in[k] = {pn[DW-2:0], 1'b0};
         end
         valid_in[k] = pv;
         den_in[k]   = pd;
         side_in[k]  = ps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DW; k++) begin
            num_ff[k]  <= num_in[k];
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DW-1];
   assign out_quo   = num_ff[DW-1];
   assign out_rem   = rem_ff[DW-1];
   assign out_side  = side_ff[DW-1];

endmodule
